// File: sv/smkrt_pkg.sv
// ============================================================================
// Sorted record table package
// Shared types, operation and status codes for the sorted record table.
// ============================================================================
package smkrt_pkg;

    localparam int DEF_TABLE_DEPTH = 64;
    localparam int CAP_W = 7;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [2:0] {
        OP_INSERT    = 3'd0,
        OP_RETIRE    = 3'd1,
        OP_FIND_ID   = 3'd2,
        OP_FIND_CONN = 3'd3,
        OP_FIND_SESS = 3'd4,
        OP_FIND_ENT  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO_ID   = 3'd1,
        ST_FULL      = 3'd2,
        ST_DUP       = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } t_state;

    // Player id sits in the lowest bits, matching the stream data layout.
    typedef struct packed {
        logic [31:0] entity_id;
        logic [63:0] session_member;
        logic [31:0] connection_id;
        logic [31:0] player_id;
    } t_rec;

    typedef struct packed {
        logic hit;
        t_rec rec;
    } t_node;

    typedef struct packed {
        logic [2:0] op;
        logic       insert;
        logic       retire;
        logic       key_nz;
        t_rec       key;
    } t_cell_ctl;

endpackage

// File: sv/smkrt_cell.sv
// ============================================================================
// Sorted record table cell
// Holds one record slot, compares it against the broadcast key and shifts
// toward either neighbor on a sorted insert or a removal.
// ============================================================================
module smkrt_cell
    import smkrt_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_left_lt,
    input  t_rec             i_left_rec,
    input  t_rec             i_right_rec,
    output logic             o_lt,
    output t_rec             o_rec,
    output logic             o_hit
);

    t_rec r_rec;
    logic w_live;
    logic w_eq;

    assign w_live = CNT_W'(INDEX) < i_count;
    assign o_lt   = w_live && (r_rec.player_id < i_ctl.key.player_id);
    assign o_rec  = r_rec;

    always_comb begin
        case (i_ctl.op)
            OP_INSERT, OP_RETIRE, OP_FIND_ID: w_eq = r_rec.player_id == i_ctl.key.player_id;
            OP_FIND_CONN: w_eq = r_rec.connection_id == i_ctl.key.connection_id;
            OP_FIND_SESS: w_eq = r_rec.session_member == i_ctl.key.session_member;
            OP_FIND_ENT:  w_eq = r_rec.entity_id == i_ctl.key.entity_id;
            default:      w_eq = 1'b0;
        endcase
    end

    assign o_hit = w_live && i_ctl.key_nz && w_eq;

    // The cell where the left neighbor is below the key and this one is not
    // is the insert position; every cell after it takes its left neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctl.insert && !o_lt) begin
            r_rec <= i_left_lt ? i_ctl.key : i_left_rec;
        end else if (i_ctl.retire && !o_lt) begin
            r_rec <= i_right_rec;
        end
    end

endmodule

// File: sv/smkrt_tree.sv
// ============================================================================
// Sorted record table match tree
// Registered reduction that picks the highest-index matching cell.
// ============================================================================
module smkrt_tree
    import smkrt_pkg::*;
#(
    parameter int N = 64
) (
    input  logic  i_clk,
    input  t_node i_leaf [N],
    output t_node o_top
);

    localparam int L = $clog2(N);
    localparam int P = 1 << L;

    t_node w_node [0:L][0:P-1];
    t_node r_node [1:L][0:P-1];

    genvar l, j;

    generate
        for (j = 0; j < P; j++) begin : g_leaf
            if (j < N) begin : g_used
                assign w_node[0][j] = i_leaf[j];
            end else begin : g_pad
                assign w_node[0][j] = '0;
            end
        end

        // Two levels of selection between registers, the last level always
        // registered. The higher index wins among matches.
        for (l = 1; l <= L; l++) begin : g_lvl
            for (j = 0; j < (P >> l); j++) begin : g_sel
                t_node w_pick;
                assign w_pick = w_node[l-1][2*j+1].hit ? w_node[l-1][2*j+1]
                                                       : w_node[l-1][2*j];
                if ((l % 2 == 0) || (l == L)) begin : g_reg
                    always_ff @(posedge i_clk) begin
                        r_node[l][j] <= w_pick;
                    end
                    assign w_node[l][j] = r_node[l][j];
                end else begin : g_comb
                    assign w_node[l][j] = w_pick;
                end
            end
        end
    endgenerate

    assign o_top = w_node[L][0];

endmodule

// File: sv/sorted_multi_key_record_table_core.sv
// ============================================================================
// Sorted multi-key record table core
// Fixed-capacity table of records kept in ascending primary id order, with
// insert, retire and lookup on any one of four keys.
// ============================================================================
// The table is a row of cells, one record each, kept sorted by player id.
// Every operation is one input transfer and one result transfer. An
// accepted item first passes through the registered match tree that
// reduces all cells to the highest-index hit; the result state then applies
// the insert shift or removal shift to the row and loads the result
// register, and the idle state follows, in which the input is ready again.
// The input side accepts only between items, but does so while an earlier
// result still waits; the next item then holds in its final cycle until
// that result has been taken.
// No clearing pass is needed after reset; a fill count marks live cells.
module sorted_multi_key_record_table_core
    import smkrt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CAP_W-1:0]  i_cfg_wdata,   // capacity_limit
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [159:0]      s_tdata,       // player_id, connection_id,
                                             // session_member, entity_id
    input  logic [2:0]        s_tuser,       // opcode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [159:0]      m_tdata,       // found_player, found_connection,
                                             // found_session, found_entity
    output logic [2:0]        m_tuser        // status
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int LAT   = ($clog2(TABLE_DEPTH) + 1) / 2;
    localparam int LAT_W = $clog2(LAT + 1);
    localparam int MW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [CAP_W-1:0] r_cap;
    logic [LAT_W-1:0] r_wait;
    logic [2:0]       r_op;
    t_rec             r_key;
    logic             r_out_valid;
    t_status          r_out_status;
    t_rec             r_out_rec;

    logic      w_fire;
    logic      w_out_free;
    logic      w_commit;
    logic      w_full;
    logic      w_do_ins;
    logic      w_do_ret;
    logic      w_key_nz;
    t_status   w_status;
    t_rec      w_found;
    t_node     w_top;
    t_cell_ctl w_ctl;

    logic  w_lt  [TABLE_DEPTH];
    logic  w_hit [TABLE_DEPTH];
    t_rec  w_rec [TABLE_DEPTH];
    t_node w_leaf[TABLE_DEPTH];

    assign w_fire     = s_tvalid && s_tready;
    assign w_out_free = !r_out_valid || m_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_tvalid) n_state = S_SEARCH;
            S_SEARCH: if (r_wait == LAT_W'(1)) n_state = S_RESULT;
            S_RESULT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready = 1'b0;
        w_commit = 1'b0;
        case (r_state)
            S_IDLE:   s_tready = 1'b1;
            S_SEARCH: ;
            S_RESULT: w_commit = w_out_free;
            default:  ;
        endcase
    end

    always_comb begin
        case (r_op)
            OP_INSERT, OP_RETIRE, OP_FIND_ID: w_key_nz = r_key.player_id != '0;
            OP_FIND_CONN: w_key_nz = r_key.connection_id != '0;
            OP_FIND_SESS: w_key_nz = r_key.session_member != '0;
            OP_FIND_ENT:  w_key_nz = r_key.entity_id != '0;
            default:      w_key_nz = 1'b0;
        endcase
    end

    assign w_full = (MW'(r_count) >= MW'(r_cap)) || (r_count >= CNT_W'(TABLE_DEPTH));

    always_comb begin
        w_status = ST_NOT_FOUND;
        w_found  = '0;
        w_do_ins = 1'b0;
        w_do_ret = 1'b0;
        case (r_op)
            OP_INSERT: begin
                if (r_key.player_id == '0) begin
                    w_status = ST_ZERO_ID;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_top.hit) begin
                    w_status = ST_DUP;
                end else begin
                    w_status = ST_OK;
                    w_do_ins = 1'b1;
                end
            end
            OP_RETIRE: begin
                if (w_top.hit) begin
                    w_status = ST_OK;
                    w_do_ret = 1'b1;
                end
            end
            OP_FIND_ID, OP_FIND_CONN, OP_FIND_SESS, OP_FIND_ENT: begin
                if (w_top.hit) begin
                    w_status = ST_OK;
                    w_found  = w_top.rec;
                end
            end
            default: ;
        endcase
    end

    assign w_ctl.op     = r_op;
    assign w_ctl.insert = w_commit && w_do_ins;
    assign w_ctl.retire = w_commit && w_do_ret;
    assign w_ctl.key_nz = w_key_nz;
    assign w_ctl.key    = r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (w_fire) begin
                r_wait <= LAT_W'(LAT);
            end else if (r_state == S_SEARCH) begin
                r_wait <= r_wait - LAT_W'(1);
            end
            if (w_ctl.insert) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_ctl.retire) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_op  <= s_tuser;
            r_key <= t_rec'(s_tdata);
        end
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_rec    <= w_found;
        end
    end

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
            logic w_left_lt;
            t_rec w_left_rec;
            t_rec w_right_rec;
            if (i == 0) begin : g_first
                assign w_left_lt  = 1'b1;
                assign w_left_rec = r_key;
            end else begin : g_mid
                assign w_left_lt  = w_lt[i-1];
                assign w_left_rec = w_rec[i-1];
            end
            if (i == TABLE_DEPTH - 1) begin : g_last
                assign w_right_rec = r_key;
            end else begin : g_next
                assign w_right_rec = w_rec[i+1];
            end

            smkrt_cell #(
                .INDEX (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_count     (r_count),
                .i_left_lt   (w_left_lt),
                .i_left_rec  (w_left_rec),
                .i_right_rec (w_right_rec),
                .o_lt        (w_lt[i]),
                .o_rec       (w_rec[i]),
                .o_hit       (w_hit[i])
            );

            assign w_leaf[i] = {w_hit[i], w_rec[i]};
        end
    endgenerate

    smkrt_tree #(
        .N (TABLE_DEPTH)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_top  (w_top)
    );

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_rec;
    assign m_tuser  = r_out_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("record count beyond table depth");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == S_RESULT))
        else $error("result raised outside the result cycle");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state == S_RESULT))
        else $error("record count changed outside a commit");

    a_insert_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.insert |-> (!w_top.hit && !w_full))
        else $error("insert committed on a duplicate or full table");

endmodule
